// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/slfd_pkg.sv
package slfd_pkg;

    localparam int LEN_BITS = 16;
    localparam int CFG_BITS = 16;
    localparam int IDX_BITS = 2;

    localparam logic [CFG_BITS-1:0] START_MARKER_RST = 16'd16018;
    localparam logic [CFG_BITS-1:0] END_MARKER_RST   = 16'd16108;
    localparam logic [CFG_BITS-1:0] MAX_PAYLOAD_RST  = 16'hFFFF;

    typedef enum logic [IDX_BITS-1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1,
        REG_MAX_PAYLOAD  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_OK       = 3'd1,
        KIND_BAD_ST   = 3'd2,
        KIND_BAD_END  = 3'd3,
        KIND_TOO_LONG = 3'd4
    } kind_t;

    typedef enum logic [6:0] {
        PH_START_LO = 7'b000_0001,
        PH_START_HI = 7'b000_0010,
        PH_LEN_LO   = 7'b000_0100,
        PH_LEN_HI   = 7'b000_1000,
        PH_PAYLOAD  = 7'b001_0000,
        PH_END_LO   = 7'b010_0000,
        PH_END_HI   = 7'b100_0000
    } phase_t;

endpackage

// File: rtl/sig_length_frame_decoder.sv
// A byte transferred on s_* is held in the input register, then its result is loaded into the
// result register and driven on m_*. Throughput: one byte per cycle while the result register
// has room; a byte that yields no result never waits on m_tready.
// Reset (rst_n, async, active low): hunt for the start marker, clear all valid
// flags and restore the register defaults (start 16018, end 16108, max 65535).
`include "assert_macros.svh"

module sig_length_frame_decoder
    import slfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    // received byte stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] rx_byte
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // [7:0] data
    output logic [2:0]          m_tuser     // [2:0] kind
);

    // Configuration registers
    logic [CFG_BITS-1:0] start_marker_reg;
    logic [CFG_BITS-1:0] end_marker_reg;
    logic [CFG_BITS-1:0] max_payload_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Deframer state
    phase_t              phase_reg, phase_next;
    logic [7:0]          held_reg, held_next;
    logic [LEN_BITS-1:0] remain_reg, remain_next;

    // Result register
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    kind_t      out_kind_reg;

    // Combinational result of the byte in the input register
    logic       res_valid;
    kind_t      res_kind;
    logic [7:0] res_data;
    logic [15:0] word;
    logic       len_fits;
    logic       in_fire;
    logic       s_fire;
    logic       out_free;

    // Register writes land at once; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
            max_payload_reg  <= MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_START_MARKER)
                start_marker_reg <= cfg_data;
            else if (cfg_index == REG_END_MARKER)
                end_marker_reg <= cfg_data;
            else if (cfg_index == REG_MAX_PAYLOAD)
                max_payload_reg <= cfg_data;
        end
    end

    // Marker and length words arrive low byte first.
    assign word = {in_byte_reg, held_reg};

    // A length must also fit the payload counter.
    assign len_fits = ((32'(word)) >> LEN_BITS) == 32'd0;

    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        remain_next = remain_reg;
        res_valid   = 1'b0;
        res_kind    = KIND_DATA;
        res_data    = 8'd0;
        unique case (phase_reg)
            PH_START_HI:
            begin
                if (word == start_marker_reg)
                    phase_next = PH_LEN_LO;
                else
                begin
                    // slide the window: newest byte becomes the candidate low byte
                    held_next = in_byte_reg;
                    res_valid = 1'b1;
                    res_kind  = KIND_BAD_ST;
                end
            end
            PH_LEN_LO:
            begin
                held_next  = in_byte_reg;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                if (word > max_payload_reg || !len_fits)
                begin
                    phase_next = PH_START_LO;
                    res_valid  = 1'b1;
                    res_kind   = KIND_TOO_LONG;
                end
                else
                begin
                    remain_next = LEN_BITS'(word);
                    // zero length skips straight to the end marker
                    phase_next  = (word == 16'd0) ? PH_END_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                remain_next = remain_reg - 1'b1;
                if (remain_next == '0)
                    phase_next = PH_END_LO;
                res_valid = 1'b1;
                res_kind  = KIND_DATA;
                res_data  = in_byte_reg;
            end
            PH_END_LO:
            begin
                held_next  = in_byte_reg;
                phase_next = PH_END_HI;
            end
            PH_END_HI:
            begin
                phase_next = PH_START_LO;
                res_valid  = 1'b1;
                res_kind   = (word == end_marker_reg) ? KIND_OK : KIND_BAD_END;
            end
            default:
            begin
                // start low byte, and any stray code
                held_next  = in_byte_reg;
                phase_next = PH_START_HI;
            end
        endcase
    end

    // Advance the input register when its result has room, or it makes none.
    assign out_free = !out_valid_reg || m_tready;
    assign in_fire  = in_valid_reg && (out_free || !res_valid);
    assign s_tready = !in_valid_reg || in_fire;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START_LO;
            held_reg      <= 8'd0;
            remain_reg    <= '0;
        end
        else
        begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (in_fire)
                in_valid_reg <= 1'b0;

            if (in_fire)
            begin
                phase_reg  <= phase_next;
                held_reg   <= held_next;
                remain_reg <= remain_next;
            end

            if (in_fire && res_valid)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: hold the byte and the result until transfer.
    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_byte_reg <= s_tdata;
        if (in_fire && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    `ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(phase_reg), "phase lost its one-hot code")
    `ASSERT_NOW(a_payload_count, phase_reg == PH_PAYLOAD, remain_reg != '0,
        "payload phase with no bytes remaining")
    `ASSERT_NEXT(a_payload_result, in_fire && phase_reg == PH_PAYLOAD,
        m_tvalid && m_tuser == KIND_DATA, "payload byte did not reach the result register")
    `ASSERT_NOW(a_verdict_zero, m_tvalid && m_tuser != KIND_DATA, m_tdata == 8'd0,
        "verdict result carries nonzero data")

endmodule
